[sv/sorted_key_priority_list_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sorted key priority list
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_PRIORITY_LIST_ASSERT_SVH
`define SORTED_KEY_PRIORITY_LIST_ASSERT_SVH
`ifndef SYNTHESIS
// Expression must hold at every clock edge.
`define SKPL_ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("skpl assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define SKPL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("skpl assertion failed");
`else
`define SKPL_ASSERT_ALWAYS(lbl, expr)
`define SKPL_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[sv/skpl_pkg.sv]
// ----------------------------------------------------------------------------
// skpl_pkg
// Types and constants shared by the sorted key priority list modules.
// ----------------------------------------------------------------------------
`default_nettype none

package skpl_pkg;

	localparam int CAPACITY   = 16;
	localparam int ITEM_WIDTH = 32;
	localparam int CNT_W      = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		OP_APPEND   = 3'd0,
		OP_PREPEND  = 3'd1,
		OP_SORTED   = 3'd2,
		OP_REM_HEAD = 3'd3,
		OP_REM_KEY  = 3'd4,
		OP_LOOKUP   = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_MISS = 2'd1,
		STAT_FULL = 2'd2
	} status_t;

	typedef enum logic {
		ST_IDLE   = 1'b0,
		ST_COMMIT = 1'b1
	} state_t;

	typedef struct packed {
		logic [2:0]         op;
		logic [31:0]        item_tag;
		logic signed [31:0] search_key;
	} in_word_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [31:0]        item_out;
		logic signed [31:0] key_out;
		logic               head_valid;
		logic signed [31:0] head_key;
		logic [4:0]         entry_count;
	} out_word_t;

	typedef struct packed {
		logic capture;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
	} stat_t;

endpackage

`default_nettype wire

[sv/skpl_ctrl.sv]
// ----------------------------------------------------------------------------
// skpl_ctrl
// Two-state controller: capture a word, then commit it to the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

module skpl_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  skpl_pkg::stat_t stat,
	output skpl_pkg::cmd_t  cmd
);

	skpl_pkg::state_t state_q;
	skpl_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= skpl_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			skpl_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = skpl_pkg::ST_COMMIT;
				end
			end
			skpl_pkg::ST_COMMIT: begin
				if (!stat.out_busy) begin
					state_d = skpl_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = skpl_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		case (state_q)
			skpl_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			skpl_pkg::ST_COMMIT: begin
				cmd.commit = !stat.out_busy;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

[sv/skpl_datapath.sv]
// ----------------------------------------------------------------------------
// skpl_datapath
// Cell chain with per-cell key compare, shift update and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sorted_key_priority_list_assert.svh"

module skpl_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  skpl_pkg::cmd_t       cmd,
	output skpl_pkg::stat_t      stat,
	input  skpl_pkg::in_word_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output skpl_pkg::out_word_t  out_data
);

	localparam int CAP = skpl_pkg::CAPACITY;
	localparam int IW  = skpl_pkg::ITEM_WIDTH;
	localparam int CW  = skpl_pkg::CNT_W;

	logic signed [31:0] cell_key_q  [CAP];
	logic [IW-1:0]      cell_item_q [CAP];
	logic [CW-1:0]      count_q;

	logic [2:0]         op_q;
	logic [IW-1:0]      item_q;
	logic signed [31:0] key_q;
	logic [CAP-1:0]     gt_q;
	logic [CAP-1:0]     eq_q;

	logic                out_valid_q;
	skpl_pkg::out_word_t out_q;

	// Compare stage: every cell checks the incoming key against its own.
	logic [CAP-1:0]     valid_c;
	logic [CAP-1:0]     gt_c;
	logic [CAP-1:0]     eq_c;
	logic [IW+31:0]     tag_ext;

	always_comb begin
		for (int i = 0; i < CAP; i++) begin
			valid_c[i] = CW'(i) < count_q;
			gt_c[i]    = valid_c[i] && (in_data.search_key < cell_key_q[i]);
			eq_c[i]    = valid_c[i] && (in_data.search_key == cell_key_q[i]);
		end
		tag_ext = {IW'(0), in_data.item_tag};
	end

	// Update stage: decide the insert or remove position and shift the chain.
	logic               full_c;
	logic               empty_c;
	logic               found_c;
	logic [CAP-1:0]     gt_pre;
	logic [CAP-1:0]     eq_pre;
	logic [CAP-1:0]     first_eq;
	logic [CAP-1:0]     ins_ge;
	logic [CAP-1:0]     ins_prev;
	logic [CAP-1:0]     rem_ge;
	logic               do_ins;
	logic               do_rem;
	logic signed [31:0] new_key;
	logic signed [31:0] sel_key;
	logic [IW-1:0]      sel_item;
	logic [1:0]         status_c;
	logic signed [31:0] up_key    [CAP];
	logic [IW-1:0]      up_item   [CAP];
	logic signed [31:0] down_key  [CAP];
	logic [IW-1:0]      down_item [CAP];
	logic signed [31:0] next_key  [CAP];
	logic [IW-1:0]      next_item [CAP];
	logic [CW-1:0]      count_n;
	logic [IW+31:0]     item_ext;
	logic [CW+4:0]      cnt_ext;

	always_comb begin
		full_c  = count_q == CW'(CAP);
		empty_c = count_q == '0;
		found_c = |eq_q;

		gt_pre[0]   = gt_q[0];
		eq_pre[0]   = eq_q[0];
		first_eq[0] = eq_q[0];
		for (int i = 1; i < CAP; i++) begin
			gt_pre[i]   = gt_pre[i-1] | gt_q[i];
			eq_pre[i]   = eq_pre[i-1] | eq_q[i];
			first_eq[i] = eq_q[i] & ~eq_pre[i-1];
		end

		sel_key  = '0;
		sel_item = '0;
		for (int i = 0; i < CAP; i++) begin
			if (first_eq[i]) begin
				sel_key  = sel_key | cell_key_q[i];
				sel_item = sel_item | cell_item_q[i];
			end
		end

		do_ins   = 1'b0;
		do_rem   = 1'b0;
		ins_ge   = '0;
		rem_ge   = '0;
		new_key  = '0;
		status_c = skpl_pkg::STAT_OK;
		case (op_q)
			skpl_pkg::OP_APPEND, skpl_pkg::OP_PREPEND, skpl_pkg::OP_SORTED: begin
				if (full_c) begin
					status_c = skpl_pkg::STAT_FULL;
				end else begin
					do_ins = 1'b1;
				end
				for (int i = 0; i < CAP; i++) begin
					if (op_q == skpl_pkg::OP_PREPEND) begin
						ins_ge[i] = 1'b1;
					end else if (op_q == skpl_pkg::OP_SORTED) begin
						ins_ge[i] = gt_pre[i] | !(CW'(i) < count_q);
					end else begin
						ins_ge[i] = !(CW'(i) < count_q);
					end
				end
				if (op_q == skpl_pkg::OP_SORTED) begin
					new_key = key_q;
				end
				sel_key  = '0;
				sel_item = '0;
			end
			skpl_pkg::OP_REM_HEAD: begin
				if (empty_c) begin
					status_c = skpl_pkg::STAT_MISS;
					sel_key  = '0;
					sel_item = '0;
				end else begin
					do_rem   = 1'b1;
					rem_ge   = '1;
					sel_key  = cell_key_q[0];
					sel_item = cell_item_q[0];
				end
			end
			skpl_pkg::OP_REM_KEY, skpl_pkg::OP_LOOKUP: begin
				if (!found_c) begin
					status_c = skpl_pkg::STAT_MISS;
				end else if (op_q == skpl_pkg::OP_REM_KEY) begin
					do_rem = 1'b1;
					rem_ge = eq_pre;
				end
			end
			default: begin
				sel_key  = '0;
				sel_item = '0;
			end
		endcase

		ins_prev[0] = 1'b0;
		up_key[0]   = new_key;
		up_item[0]  = item_q;
		for (int i = 1; i < CAP; i++) begin
			ins_prev[i] = ins_ge[i-1];
			up_key[i]   = cell_key_q[i-1];
			up_item[i]  = cell_item_q[i-1];
		end
		for (int i = 0; i < CAP - 1; i++) begin
			down_key[i]  = cell_key_q[i+1];
			down_item[i] = cell_item_q[i+1];
		end
		down_key[CAP-1]  = cell_key_q[CAP-1];
		down_item[CAP-1] = cell_item_q[CAP-1];

		for (int i = 0; i < CAP; i++) begin
			next_key[i]  = cell_key_q[i];
			next_item[i] = cell_item_q[i];
			if (do_ins && ins_ge[i]) begin
				if (ins_prev[i]) begin
					next_key[i]  = up_key[i];
					next_item[i] = up_item[i];
				end else begin
					next_key[i]  = new_key;
					next_item[i] = item_q;
				end
			end else if (do_rem && rem_ge[i]) begin
				next_key[i]  = down_key[i];
				next_item[i] = down_item[i];
			end
		end

		count_n = count_q;
		if (do_ins) begin
			count_n = count_q + CW'(1);
		end else if (do_rem) begin
			count_n = count_q - CW'(1);
		end

		item_ext = {32'(0), sel_item};
		cnt_ext  = {5'(0), count_n};
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= in_data.op;
			item_q <= tag_ext[IW-1:0];
			key_q  <= in_data.search_key;
			gt_q   <= gt_c;
			eq_q   <= eq_c;
		end
		if (cmd.commit) begin
			for (int i = 0; i < CAP; i++) begin
				cell_key_q[i]  <= next_key[i];
				cell_item_q[i] <= next_item[i];
			end
			out_q.status      <= status_c;
			out_q.item_out    <= item_ext[31:0];
			out_q.key_out     <= sel_key;
			out_q.head_valid  <= count_n != '0;
			out_q.head_key    <= (count_n != '0) ? next_key[0] : 32'sd0;
			out_q.entry_count <= cnt_ext[4:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				count_q     <= count_n;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.out_busy = out_valid_q && !out_ready;
	assign out_valid     = out_valid_q;
	assign out_data      = out_q;

	`SKPL_ASSERT_ALWAYS(a_count_bound, count_q <= CW'(CAP))
	`SKPL_ASSERT_NEXT(a_commit_shows, cmd.commit, out_valid_q)
	`SKPL_ASSERT_NEXT(a_count_hold, !cmd.commit, $stable(count_q))
	`SKPL_ASSERT_ALWAYS(a_no_overwrite, !(cmd.commit && stat.out_busy))

endmodule

`default_nettype wire

[sv/sorted_key_priority_list.sv]
// A result word is offered after the commit step that follows the capture of its input word.
// Each word takes a compare step, then a shift update of the cells; no new word is taken before that update.
// A waiting result does not block the compare of the next word; only the update waits.
// Reset (arst_n low) empties the list and drops any pending result word at once.
// Cell key and item storage is not reset; only the entry count marks valid cells.
// ----------------------------------------------------------------------------
// sorted_key_priority_list
// Ordered list of keyed entries with sorted insert, removal and lookup.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_priority_list (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  skpl_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output skpl_pkg::out_word_t out_data
);

	// The controller paces each word through two steps. In the first, the
	// accepted word is latched together with every cell's comparison of its
	// key, so that the datapath holds one greater-than and one equal flag per
	// cell. In the second, those flags pick the position, the chain shifts up
	// for an insert or down for a removal, and the result word is loaded.

	skpl_pkg::cmd_t  cmd;
	skpl_pkg::stat_t stat;

	skpl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The result register parts the two sides: the update step is held back
	// only while an earlier result word is still waiting to be taken.
	skpl_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

[dv/skpl_result_check.sv]
// ----------------------------------------------------------------------------
// Result check for the sorted key priority list
// Watches both channels, keeps a model of the list and compares each result
// word against the word predicted for the oldest outstanding input word.
// ----------------------------------------------------------------------------
module skpl_result_check (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  skpl_pkg::in_word_t  in_data,
	input  logic                out_valid,
	input  logic                out_ready,
	input  skpl_pkg::out_word_t out_data,
	output int                  mismatches,
	output int                  waiting
);
	timeunit 1ns;
	timeprecision 1ps;

	logic signed [31:0]  list_key  [skpl_pkg::CAPACITY];
	logic [31:0]         list_item [skpl_pkg::CAPACITY];
	int                  list_len = 0;
	int                  fault_count = 0;
	skpl_pkg::out_word_t predicted_q [$];

	assign mismatches = fault_count;

	function automatic void insert_entry(input int pos, input logic [31:0] tag,
			input logic signed [31:0] key);
		for (int i = list_len; i > pos; i--) begin
			list_key[i]  = list_key[i - 1];
			list_item[i] = list_item[i - 1];
		end
		list_key[pos]  = key;
		list_item[pos] = tag;
		list_len++;
	endfunction

	function automatic void remove_entry(input int pos);
		for (int i = pos; i + 1 < list_len; i++) begin
			list_key[i]  = list_key[i + 1];
			list_item[i] = list_item[i + 1];
		end
		list_len--;
	endfunction

	function automatic int find_key(input logic signed [31:0] key);
		for (int i = 0; i < list_len; i++) begin
			if (list_key[i] == key)
				return i;
		end
		return list_len;
	endfunction

	// Applies one operation to the model list and returns the result word.
	function automatic skpl_pkg::out_word_t apply_list_op(input skpl_pkg::in_word_t w);
		skpl_pkg::out_word_t r;
		int                  pos;
		logic signed [31:0]  key;
		r = '0;
		r.status = skpl_pkg::STAT_OK;
		key = $signed(w.search_key);
		case (w.op)
			skpl_pkg::OP_APPEND, skpl_pkg::OP_PREPEND, skpl_pkg::OP_SORTED: begin
				if (list_len >= skpl_pkg::CAPACITY) begin
					r.status = skpl_pkg::STAT_FULL;
				end else if (w.op == skpl_pkg::OP_APPEND) begin
					insert_entry(list_len, w.item_tag, '0);
				end else if (w.op == skpl_pkg::OP_PREPEND) begin
					insert_entry(0, w.item_tag, '0);
				end else begin
					// Equal keys stay ahead of the new entry.
					pos = 0;
					while (pos < list_len && !(key < list_key[pos]))
						pos++;
					insert_entry(pos, w.item_tag, key);
				end
			end
			skpl_pkg::OP_REM_HEAD: begin
				if (list_len == 0) begin
					r.status = skpl_pkg::STAT_MISS;
				end else begin
					r.item_out = list_item[0];
					r.key_out  = list_key[0];
					remove_entry(0);
				end
			end
			skpl_pkg::OP_REM_KEY, skpl_pkg::OP_LOOKUP: begin
				pos = find_key(key);
				if (pos >= list_len) begin
					r.status = skpl_pkg::STAT_MISS;
				end else begin
					r.item_out = list_item[pos];
					r.key_out  = list_key[pos];
					if (w.op == skpl_pkg::OP_REM_KEY)
						remove_entry(pos);
				end
			end
			default: ;
		endcase
		r.head_valid  = (list_len > 0);
		r.head_key    = (list_len > 0) ? list_key[0] : '0;
		r.entry_count = 5'(list_len);
		return r;
	endfunction

	task automatic note_fault(input string what, input skpl_pkg::out_word_t want,
			input skpl_pkg::out_word_t got);
		fault_count++;
		if (fault_count <= 10)
			$display({"%0t ns: %s: expected status=%0d item=%h key=%0d ",
				"head_valid=%b head_key=%0d count=%0d; got status=%0d item=%h ",
				"key=%0d head_valid=%b head_key=%0d count=%0d"},
				$time, what, want.status, want.item_out, want.key_out,
				want.head_valid, want.head_key, want.entry_count, got.status,
				got.item_out, got.key_out, got.head_valid, got.head_key,
				got.entry_count);
	endtask

	always @(posedge clk or negedge arst_n) begin
		skpl_pkg::out_word_t want;
		if (!arst_n) begin
			list_len = 0;
			predicted_q.delete();
			waiting <= 0;
		end else begin
			// A result word always belongs to an earlier input word, so the
			// result side is handled before the input side.
			if (out_valid && out_ready) begin
				if (predicted_q.size() == 0) begin
					note_fault("result word with nothing outstanding", '0, out_data);
				end else begin
					want = predicted_q.pop_front();
					if (want.status !== out_data.status
							|| want.item_out !== out_data.item_out
							|| want.key_out !== out_data.key_out
							|| want.head_valid !== out_data.head_valid
							|| want.head_key !== out_data.head_key
							|| want.entry_count !== out_data.entry_count)
						note_fault("result word mismatch", want, out_data);
				end
			end
			if (in_valid && in_ready)
				predicted_q.push_back(apply_list_op(in_data));
			waiting <= predicted_q.size();
		end
	end

endmodule

[dv/sorted_key_priority_list_test.sv]
// ----------------------------------------------------------------------------
// Sorted key priority list testbench
// Drives a directed sequence through every operation and corner of the list,
// then runs of random words that fill and drain it, under three patterns of
// sender and receiver stalls. Results are checked by skpl_result_check.
// ----------------------------------------------------------------------------
module sorted_key_priority_list_test;
	timeunit 1ns;
	timeprecision 1ps;

	// Operation codes the block does not define; they must leave the list alone.
	localparam logic [2:0] OP_SPARE_LO = 3'd6;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;

	localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;

	localparam int WORDS_PER_PHASE = 250;

	// Each random run leans towards filling, draining or neither.
	typedef enum int {RUN_FILL, RUN_DRAIN, RUN_MIXED} run_mode_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	skpl_pkg::in_word_t  in_data = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	skpl_pkg::out_word_t out_data;
	int                  mismatches;
	int                  waiting;
	int                  send_idle_pct = 15;
	int                  recv_idle_pct = 48;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	sorted_key_priority_list uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	skpl_result_check list_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.mismatches (mismatches),
		.waiting    (waiting)
	);

	// The receiver stalls at random, at whatever rate the current phase sets.
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_idle_pct);

	// Offers one word, possibly after a few idle cycles, and returns at the
	// edge where it is taken. Valid is left high so that back-to-back words
	// never see it dropped and raised within one time step.
	task automatic send_word(input logic [2:0] op, input logic [31:0] tag,
			input logic signed [31:0] key);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= {op, tag, key};
		do @(posedge clk); while (!in_ready);
	endtask

	// Holds the sender back until every outstanding result word has arrived.
	// The count from the checker is registered and lags, hence the leading wait.
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (waiting != 0);
	endtask

	// Most keys come from a narrow band around zero so that equal keys and
	// key hits are common; the rest are the extremes or fully random.
	function automatic logic signed [31:0] pick_key();
		int r;
		r = $urandom_range(99);
		if (r < 75)
			return $signed(32'($urandom_range(8))) - 32'sd4;
		else if (r < 80)
			return KEY_MIN;
		else if (r < 85)
			return KEY_MAX;
		return $urandom;
	endfunction

	// Zero is a legal tag and all ones is its mirror; both get extra weight.
	function automatic logic [31:0] pick_tag();
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return '0;
		else if (r < 20)
			return '1;
		return $urandom;
	endfunction

	function automatic logic [2:0] pick_op(input run_mode_t mode);
		int r;
		r = $urandom_range(99);
		if (r < 2)
			return ($urandom_range(1) != 0) ? OP_SPARE_HI : OP_SPARE_LO;
		case (mode)
			RUN_FILL: begin
				if (r < 55) return skpl_pkg::OP_SORTED;
				if (r < 70) return skpl_pkg::OP_APPEND;
				if (r < 82) return skpl_pkg::OP_PREPEND;
				if (r < 92) return skpl_pkg::OP_LOOKUP;
				if (r < 96) return skpl_pkg::OP_REM_KEY;
				return skpl_pkg::OP_REM_HEAD;
			end
			RUN_DRAIN: begin
				if (r < 35) return skpl_pkg::OP_REM_HEAD;
				if (r < 70) return skpl_pkg::OP_REM_KEY;
				if (r < 85) return skpl_pkg::OP_LOOKUP;
				return skpl_pkg::OP_SORTED;
			end
			default: begin
				if (r < 40) return skpl_pkg::OP_SORTED;
				if (r < 48) return skpl_pkg::OP_APPEND;
				if (r < 56) return skpl_pkg::OP_PREPEND;
				if (r < 70) return skpl_pkg::OP_REM_HEAD;
				if (r < 85) return skpl_pkg::OP_REM_KEY;
				return skpl_pkg::OP_LOOKUP;
			end
		endcase
	endfunction

	initial begin
		int        sent;
		int        run_len;
		run_mode_t mode;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Every removal and lookup on the empty list must miss.
		send_word(skpl_pkg::OP_REM_HEAD, pick_tag(), 32'sd0);
		send_word(skpl_pkg::OP_REM_KEY, pick_tag(), 32'sd0);
		send_word(skpl_pkg::OP_LOOKUP, pick_tag(), 32'sd0);

		// Two zero-key entries, then the key extremes and an equal key, which
		// must land after both zeros and before the largest key.
		send_word(skpl_pkg::OP_APPEND, 32'h0000_0000, KEY_MAX);
		send_word(skpl_pkg::OP_PREPEND, 32'hffff_ffff, KEY_MIN);
		send_word(skpl_pkg::OP_SORTED, 32'h5a5a_a5a5, KEY_MIN);
		send_word(skpl_pkg::OP_SORTED, 32'ha5a5_5a5a, KEY_MAX);
		send_word(skpl_pkg::OP_SORTED, 32'h1234_5678, 32'sd0);

		// A lookup of key zero must return the first zero entry, not a later one.
		send_word(skpl_pkg::OP_LOOKUP, pick_tag(), 32'sd0);
		send_word(OP_SPARE_LO, $urandom, $urandom);
		send_word(OP_SPARE_HI, $urandom, $urandom);

		// Fill the list to capacity, then every insert must be refused.
		repeat (skpl_pkg::CAPACITY - 5)
			send_word(skpl_pkg::OP_APPEND, pick_tag(), pick_key());
		send_word(skpl_pkg::OP_APPEND, pick_tag(), pick_key());
		send_word(skpl_pkg::OP_PREPEND, pick_tag(), pick_key());
		send_word(skpl_pkg::OP_SORTED, pick_tag(), 32'sd1);
		send_word(skpl_pkg::OP_REM_KEY, pick_tag(), KEY_MAX);
		send_word(skpl_pkg::OP_REM_HEAD, pick_tag(), pick_key());
		drain_results();

		// Random part in three phases: sender mostly busy and receiver often
		// stalled, then the reverse, then no stalls at all.
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 48 : 0;
			recv_idle_pct = (phase == 0) ? 48 : (phase == 1) ? 15 : 0;
			sent = 0;
			while (sent < WORDS_PER_PHASE) begin
				mode = run_mode_t'($urandom_range(2));
				run_len = $urandom_range(24, 4);
				for (int i = 0; i < run_len; i++)
					send_word(pick_op(mode), pick_tag(), pick_key());
				sent += run_len;
			end
			drain_results();
		end

		repeat (4) @(posedge clk);
		if (mismatches == 0 && waiting == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Hard stop well beyond the slowest correct run.
	initial begin
		#1_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
